// ===== sv/salru_pkg.sv =====
// shared constants and types for the set-associative cache tag and lru block
// no dependencies; used by salru_row, set_assoc_cache_lru_tags and its checker
package salru_pkg;

	localparam int ADDR_W    = 32;
	localparam int PEN_W     = 8;
	localparam int WAY_OUT_W = 3;
	localparam int WAY_IDX_W = 4;

	localparam logic [PEN_W-1:0] PEN_RESET = 8'd50;

	// lookup outcome of one set row
	typedef struct packed {
		logic                 hit;
		logic [WAY_IDX_W-1:0] way;
	} lookup_t;

endpackage

// ===== sv/set_assoc_cache_lru_tags.sv =====
// set-associative cache tag store with lru ranks, one row of WAYS entries per set
// an item's set row is registered, then its result loads once result_stall allows;
// new items wait meanwhile: the set row is read-modify-written in the single-port memory
// reset: a clearing pass over every set of the tag memory, during which access_stall is high;
// miss_penalty resets to 50 and config writes are taken at any time
// depends on salru_pkg and salru_row
module set_assoc_cache_lru_tags #(
	parameter int SETS        = 256,
	parameter int WAYS        = 8,
	parameter int OFFSET_BITS = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [salru_pkg::PEN_W-1:0]          miss_penalty,
	input  logic                                 access_valid,
	output logic                                 access_stall,
	input  logic [salru_pkg::ADDR_W-1:0]         access_address,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic                                 hit,
	output logic [salru_pkg::PEN_W-1:0]          stall_cycles,
	output logic [salru_pkg::WAY_OUT_W-1:0]      way_used
);
	import salru_pkg::*;

	localparam int IDX_W  = $clog2(SETS);
	localparam int TAG_W  = ADDR_W - OFFSET_BITS - IDX_W;
	localparam int RANK_W = $clog2(WAYS);
	localparam int ROW_W  = WAYS * (1 + TAG_W + RANK_W);
	localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(SETS - 1);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [PEN_W-1:0]   penalty_q;
	logic               result_valid_q;
	logic               hit_q;
	logic [PEN_W-1:0]   stall_cycles_q;
	logic [WAY_OUT_W-1:0] way_used_q;

	logic [IDX_W-1:0]   idx_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [ROW_W-1:0]   rd_row_s1;

	logic [ROW_W-1:0]   mem [SETS];

	logic               acc_fire;
	logic               can_load;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [ROW_W-1:0]   mem_wdata;
	logic [IDX_W-1:0]   idx_raw;
	logic [IDX_W-1:0]   idx;

	logic [WAYS-1:0]             rd_valid;
	logic [WAYS-1:0][TAG_W-1:0]  rd_tags;
	logic [WAYS-1:0][RANK_W-1:0] rd_ranks;
	logic [WAYS-1:0]             up_valid;
	logic [WAYS-1:0][TAG_W-1:0]  up_tags;
	logic [WAYS-1:0][RANK_W-1:0] up_ranks;
	lookup_t                     lookup;

	assign cfg_ready    = 1'b1;
	assign access_stall = (state_q != S_IDLE);
	assign acc_fire     = access_valid && !access_stall;
	assign can_load     = !result_valid_q || !result_stall;

	// index field wraps when the set count is not a power of two
	assign idx_raw = access_address[OFFSET_BITS +: IDX_W];
	assign idx     = ({1'b0, idx_raw} >= (IDX_W + 1)'(SETS)) ? idx_raw - IDX_W'(SETS) : idx_raw;

	assign {rd_valid, rd_tags, rd_ranks} = rd_row_s1;

	salru_row #(
		.WAYS   (WAYS),
		.TAG_W  (TAG_W),
		.RANK_W (RANK_W)
	) u_row (
		.valid     (rd_valid),
		.tags      (rd_tags),
		.ranks     (rd_ranks),
		.tag_in    (tag_s1),
		.new_valid (up_valid),
		.new_tags  (up_tags),
		.new_ranks (up_ranks),
		.lookup    (lookup)
	);

	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_LOOK && can_load);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q : idx_s1;
	assign mem_wdata = (state_q == S_CLEAR) ? '0 : {up_valid, up_tags, up_ranks};

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (acc_fire)
			rd_row_s1 <= mem[idx];
	end

	always_ff @(posedge clk) begin
		if (acc_fire) begin
			idx_s1 <= idx;
			tag_s1 <= access_address[ADDR_W-1 -: TAG_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			penalty_q <= PEN_RESET;
		else if (cfg_valid && cfg_ready)
			penalty_q <= miss_penalty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
			hit_q          <= 1'b0;
			stall_cycles_q <= '0;
			way_used_q     <= '0;
		end else begin
			// in S_LOOK the output register either holds or reloads
			if (result_valid_q && !result_stall && state_q != S_LOOK)
				result_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SET)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (acc_fire)
						state_q <= S_LOOK;
				end
				S_LOOK: begin
					// hold the row until the output register frees up
					if (can_load) begin
						result_valid_q <= 1'b1;
						hit_q          <= lookup.hit;
						stall_cycles_q <= lookup.hit ? '0 : penalty_q;
						way_used_q     <= lookup.way[WAY_OUT_W-1:0];
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign hit          = hit_q;
	assign stall_cycles = stall_cycles_q;
	assign way_used     = way_used_q;

endmodule

// ===== sv/salru_row.sv =====
// hit detection, victim choice and lru rank update for one set row
// depends on salru_pkg (lookup_t)
module salru_row #(
	parameter int WAYS  = 8,
	parameter int TAG_W = 19,
	parameter int RANK_W = 3
) (
	input  logic [WAYS-1:0]              valid,
	input  logic [WAYS-1:0][TAG_W-1:0]   tags,
	input  logic [WAYS-1:0][RANK_W-1:0]  ranks,
	input  logic [TAG_W-1:0]             tag_in,
	output logic [WAYS-1:0]              new_valid,
	output logic [WAYS-1:0][TAG_W-1:0]   new_tags,
	output logic [WAYS-1:0][RANK_W-1:0]  new_ranks,
	output salru_pkg::lookup_t           lookup
);
	import salru_pkg::*;

	localparam logic [RANK_W-1:0] TOP = RANK_W'(WAYS - 1);

	logic [WAYS-1:0]   hit_vec;
	logic [WAYS-1:0]   min_vec;
	logic [RANK_W-1:0] hit_way;
	logic [RANK_W-1:0] inv_way;
	logic [RANK_W-1:0] min_way;
	logic [RANK_W-1:0] sel_way;
	logic [RANK_W-1:0] floor_rank;
	logic              any_hit;
	logic              any_inv;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			hit_vec[i] = valid[i] && (tags[i] == tag_in);
			// lowest rank, ties broken toward the lower way
			min_vec[i] = 1'b1;
			for (int j = 0; j < WAYS; j++) begin
				if (j < i && !(ranks[i] < ranks[j]))
					min_vec[i] = 1'b0;
				if (j > i && !(ranks[i] <= ranks[j]))
					min_vec[i] = 1'b0;
			end
		end
	end

	always_comb begin
		hit_way = '0;
		inv_way = '0;
		min_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i])
				hit_way = RANK_W'(i);
			if (!valid[i])
				inv_way = RANK_W'(i);
			if (min_vec[i])
				min_way = RANK_W'(i);
		end
	end

	assign any_hit    = |hit_vec;
	assign any_inv    = ~&valid;
	assign sel_way    = any_hit ? hit_way : (any_inv ? inv_way : min_way);
	assign floor_rank = any_hit ? ranks[hit_way] : '0;

	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			new_valid[i] = valid[i];
			new_tags[i]  = tags[i];
			new_ranks[i] = (valid[i] && ranks[i] > floor_rank) ? ranks[i] - 1'b1 : ranks[i];
			if (RANK_W'(i) == sel_way) begin
				new_valid[i] = 1'b1;
				new_tags[i]  = tag_in;
				new_ranks[i] = TOP;
			end
		end
	end

	assign lookup.hit = any_hit;
	assign lookup.way = WAY_IDX_W'(sel_way);

endmodule

// ===== sv/salru_checker.sv =====
// port-level checks for set_assoc_cache_lru_tags, bound to every instance
// depends on salru_pkg for port widths
module salru_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            access_valid,
	input logic                            access_stall,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic                            hit,
	input logic [salru_pkg::PEN_W-1:0]     stall_cycles
);
	import salru_pkg::*;

	logic acc_fire;
	assign acc_fire = access_valid && !access_stall;

	// a waiting result is not withdrawn
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_hit_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && hit |-> stall_cycles == '0)
		else $error("hit reported nonzero stall count");

	// one item in flight: input closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		acc_fire |=> access_stall)
		else $error("second item accepted while one is in flight");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(acc_fire, 2))
		else $error("result appeared without a matching item");

endmodule

bind set_assoc_cache_lru_tags salru_checker u_salru_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.access_valid (access_valid),
	.access_stall (access_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.hit          (hit),
	.stall_cycles (stall_cycles)
);
